@@ hw/rtl/smsc_pkg.sv @@
// Shared types and constants of the six-axis motion setpoint conditioner.
package smsc_pkg;

    // Fixed widths of the channel fields.
    localparam int AXES              = 6;
    localparam int TRANS_AXES        = 3;
    localparam int FIELD_W           = 16;
    localparam int SEQ_W             = 32;
    localparam int STEP_W            = 15;
    localparam int VALUE_WIDTH_DEF   = 16;
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(256);

    // Item kinds on the input channel.
    typedef enum logic {
        CMD_PACKET = 1'b0,
        CMD_TICK   = 1'b1
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_MAX_TRANSLATION = 1'b0,
        REG_MAX_ROTATION    = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_cmd                       cmd;
        logic [SEQ_W-1:0]           sequence_id;
        logic signed [FIELD_W-1:0]  surge_in;
        logic signed [FIELD_W-1:0]  sway_in;
        logic signed [FIELD_W-1:0]  heave_in;
        logic signed [FIELD_W-1:0]  roll_in;
        logic signed [FIELD_W-1:0]  pitch_in;
        logic signed [FIELD_W-1:0]  yaw_in;
    } t_in_item;

    typedef struct packed {
        logic signed [FIELD_W-1:0]  surge_out;
        logic signed [FIELD_W-1:0]  sway_out;
        logic signed [FIELD_W-1:0]  heave_out;
        logic signed [FIELD_W-1:0]  roll_out;
        logic signed [FIELD_W-1:0]  pitch_out;
        logic signed [FIELD_W-1:0]  yaw_out;
        logic                       extrapolated;
    } t_out_item;

    // Decision for one item, from the sequencing logic to the datapath.
    typedef struct packed {
        logic has_result;   // item produces a result transfer
        logic extrap;       // tick with nothing pending: send the extrapolation
        logic take_mid;     // packet replaces the older sample
        logic take_new;     // packet shifts the samples and becomes the setpoint
        logic is_packet;    // item is a motion packet
    } t_ctrl;

endpackage

@@ hw/rtl/smsc_ifs.sv @@
// Valid/ready channel interfaces for items, results and configuration writes.
interface smsc_in_if import smsc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface smsc_out_if import smsc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface smsc_cfg_if import smsc_pkg::*; ();
    logic              valid;
    logic              ready;
    t_cfg_reg          index;
    logic [STEP_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/smsc_ctrl.sv @@
// Sequence ordering and send decision for one input item.
module smsc_ctrl import smsc_pkg::*; (
    input  t_cmd             i_cmd,
    input  logic [SEQ_W-1:0] i_seq,
    input  logic [SEQ_W-1:0] i_newest_seq,
    input  logic [SEQ_W-1:0] i_older_seq,
    input  logic             i_pending,
    input  logic             i_awaiting_first,
    output t_ctrl            o_ctrl
);

    logic w_below_older;
    logic w_below_newest;

    // Unsigned ordering of the packet id against both stored samples.
    assign w_below_older  = (i_seq < i_older_seq);
    assign w_below_newest = (i_seq < i_newest_seq);

    always_comb begin
        o_ctrl = '0;
        case (i_cmd)
            CMD_TICK: begin
                // A tick always sends; it extrapolates when nothing is pending.
                o_ctrl.has_result = 1'b1;
                o_ctrl.extrap     = !i_pending;
            end
            default: begin
                o_ctrl.is_packet  = 1'b1;
                o_ctrl.take_mid   = !w_below_older && w_below_newest;
                o_ctrl.take_new   = !w_below_newest;
                o_ctrl.has_result = i_awaiting_first;
            end
        endcase
    end

endmodule

@@ hw/rtl/smsc_axis.sv @@
// Per-axis slew limiter and linear extrapolator with saturation.
module smsc_axis import smsc_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic [FIELD_W-1:0]            i_field,
    input  logic signed [VALUE_WIDTH-1:0] i_setpoint,
    input  logic signed [VALUE_WIDTH-1:0] i_newest,
    input  logic signed [VALUE_WIDTH-1:0] i_older,
    input  logic [STEP_W-1:0]             i_step,
    output logic signed [VALUE_WIDTH-1:0] o_limited,
    output logic signed [VALUE_WIDTH-1:0] o_extrap
);

    // Working width holds a difference, a step and a doubled value.
    localparam int CW = ((VALUE_WIDTH > FIELD_W) ? VALUE_WIDTH : FIELD_W) + 2;
    localparam logic signed [CW-1:0] SAT_HI =
        $signed({{(CW-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}});
    localparam logic signed [CW-1:0] SAT_LO =
        $signed({{(CW-VALUE_WIDTH+1){1'b1}}, {(VALUE_WIDTH-1){1'b0}}});

    function automatic logic signed [VALUE_WIDTH-1:0] sat(input logic signed [CW-1:0] v);
        logic signed [VALUE_WIDTH-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[VALUE_WIDTH-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[VALUE_WIDTH-1:0];
        end else begin
            r = v[VALUE_WIDTH-1:0];
        end
        return r;
    endfunction

    logic signed [VALUE_WIDTH-1:0] w_in;
    logic signed [CW-1:0]          w_in_x;
    logic signed [CW-1:0]          w_sp_x;
    logic signed [CW-1:0]          w_step_x;
    logic signed [CW-1:0]          w_diff;
    logic signed [CW-1:0]          w_nw_x;
    logic signed [CW-1:0]          w_ol_x;

    // The field is read as the low value bits, zero-extended when the value is wider.
    if (VALUE_WIDTH <= FIELD_W) begin : g_narrow
        assign w_in = i_field[VALUE_WIDTH-1:0];
    end else begin : g_wide
        assign w_in = {{(VALUE_WIDTH-FIELD_W){1'b0}}, i_field};
    end

    assign w_in_x   = CW'(w_in);
    assign w_sp_x   = CW'(i_setpoint);
    assign w_step_x = $signed(CW'(i_step));
    assign w_diff   = w_in_x - w_sp_x;
    assign w_nw_x   = CW'(i_newest);
    assign w_ol_x   = CW'(i_older);

    // Move toward the input by at most one step.
    always_comb begin
        if (w_diff > w_step_x) begin
            o_limited = sat(w_sp_x + w_step_x);
        end else if (w_diff < -w_step_x) begin
            o_limited = sat(w_sp_x - w_step_x);
        end else begin
            o_limited = w_in;
        end
    end

    // Linear extrapolation from the two stored samples.
    assign o_extrap = sat((w_nw_x <<< 1) - w_ol_x);

endmodule

@@ hw/rtl/six_axis_motion_setpoint_conditioner.sv @@
// Results are registered: an item passes the input register, then the output register.
// Throughput: one item per cycle, all six axes in parallel in the single stage;
// an item waits in the input register while the output holds an untaken result.
// Reset (synchronous, active low): setpoint, samples and ids clear to zero,
// no setpoint is pending, the block awaits its first packet, both steps are 256.
// Top level of the six-axis motion setpoint conditioner.
module six_axis_motion_setpoint_conditioner import smsc_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    smsc_cfg_if.sink    i_cfg,
    smsc_in_if.sink     i_in,
    smsc_out_if.source  o_out
);

    // Configuration registers.
    logic [STEP_W-1:0] r_trans_step;
    logic [STEP_W-1:0] r_rot_step;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trans_step <= STEP_RESET;
            r_rot_step   <= STEP_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_MAX_TRANSLATION: r_trans_step <= i_cfg.data;
                REG_MAX_ROTATION:    r_rot_step   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Input register.
    logic     r_in_valid;
    t_in_item r_in;
    logic     w_fire;
    logic     r_out_valid;

    assign w_fire     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
    end

    // Conditioner state.
    logic signed [VALUE_WIDTH-1:0] r_setpoint [AXES];
    logic signed [VALUE_WIDTH-1:0] r_newest   [AXES];
    logic signed [VALUE_WIDTH-1:0] r_older    [AXES];
    logic signed [VALUE_WIDTH-1:0] n_setpoint [AXES];
    logic signed [VALUE_WIDTH-1:0] n_newest   [AXES];
    logic signed [VALUE_WIDTH-1:0] n_older    [AXES];
    logic [SEQ_W-1:0]              r_newest_seq;
    logic [SEQ_W-1:0]              r_older_seq;
    logic                          r_pending;
    logic                          r_awaiting_first;

    // Ordering and send decision.
    t_ctrl w_ctrl;

    smsc_ctrl u_ctrl (
        .i_cmd            (r_in.cmd),
        .i_seq            (r_in.sequence_id),
        .i_newest_seq     (r_newest_seq),
        .i_older_seq      (r_older_seq),
        .i_pending        (r_pending),
        .i_awaiting_first (r_awaiting_first),
        .o_ctrl           (w_ctrl)
    );

    // Axis lanes.
    logic [FIELD_W-1:0] w_field   [AXES];
    logic [FIELD_W-1:0] w_out_fld [AXES];

    assign w_field[0] = r_in.surge_in;
    assign w_field[1] = r_in.sway_in;
    assign w_field[2] = r_in.heave_in;
    assign w_field[3] = r_in.roll_in;
    assign w_field[4] = r_in.pitch_in;
    assign w_field[5] = r_in.yaw_in;

    for (genvar k = 0; k < AXES; k++) begin : g_axis
        logic signed [VALUE_WIDTH-1:0] w_limited;
        logic signed [VALUE_WIDTH-1:0] w_extrap;

        smsc_axis #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_axis (
            .i_field    (w_field[k]),
            .i_setpoint (r_setpoint[k]),
            .i_newest   (r_newest[k]),
            .i_older    (r_older[k]),
            .i_step     ((k < TRANS_AXES) ? r_trans_step : r_rot_step),
            .o_limited  (w_limited),
            .o_extrap   (w_extrap)
        );

        // Next state of this axis.
        always_comb begin
            n_setpoint[k] = r_setpoint[k];
            n_newest[k]   = r_newest[k];
            n_older[k]    = r_older[k];
            if (w_ctrl.extrap) begin
                n_setpoint[k] = w_extrap;
            end
            if (w_ctrl.take_mid) begin
                n_older[k] = w_limited;
            end
            if (w_ctrl.take_new) begin
                n_older[k]    = r_newest[k];
                n_newest[k]   = w_limited;
                n_setpoint[k] = w_limited;
            end
        end

        // The sent field is the low bits of the setpoint, zero-extended if narrower.
        if (VALUE_WIDTH >= FIELD_W) begin : g_out_trunc
            assign w_out_fld[k] = n_setpoint[k][FIELD_W-1:0];
        end else begin : g_out_ext
            assign w_out_fld[k] = {{(FIELD_W-VALUE_WIDTH){1'b0}}, n_setpoint[k]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_setpoint[k] <= '0;
                r_newest[k]   <= '0;
                r_older[k]    <= '0;
            end else if (w_fire) begin
                r_setpoint[k] <= n_setpoint[k];
                r_newest[k]   <= n_newest[k];
                r_older[k]    <= n_older[k];
            end
        end
    end

    // Sequence ids and flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest_seq     <= '0;
            r_older_seq      <= '0;
            r_pending        <= 1'b0;
            r_awaiting_first <= 1'b1;
        end else if (w_fire) begin
            if (w_ctrl.take_mid) begin
                r_older_seq <= r_in.sequence_id;
            end
            if (w_ctrl.take_new) begin
                r_older_seq  <= r_newest_seq;
                r_newest_seq <= r_in.sequence_id;
            end
            // A packet leaves a setpoint pending unless it is sent at once.
            r_pending <= w_ctrl.is_packet && !w_ctrl.has_result;
            if (w_ctrl.is_packet) begin
                r_awaiting_first <= 1'b0;
            end
        end
    end

    // Output register.
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_ctrl.has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_ctrl.has_result) begin
            r_out.surge_out    <= w_out_fld[0];
            r_out.sway_out     <= w_out_fld[1];
            r_out.heave_out    <= w_out_fld[2];
            r_out.roll_out     <= w_out_fld[3];
            r_out.pitch_out    <= w_out_fld[4];
            r_out.yaw_out      <= w_out_fld[5];
            r_out.extrapolated <= w_ctrl.extrap;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Once the first packet is taken the block never awaits one again.
    a_first_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_awaiting_first |=> !r_awaiting_first)
        else $error("awaiting_first set again after the first packet");

    // The older sample never carries a newer id than the newest sample.
    a_seq_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_older_seq <= r_newest_seq)
        else $error("older sequence id exceeds newest sequence id");

    // Every processed tick produces a result transfer.
    a_tick_sends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in.cmd == CMD_TICK) |=> r_out_valid)
        else $error("tick processed without a result");

    // A tick with a pending setpoint never sends an extrapolation.
    a_pending_no_extrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in.cmd == CMD_TICK && r_pending) |=> !r_out.extrapolated)
        else $error("extrapolation sent while a setpoint was pending");

endmodule

@@ test/six_axis_motion_setpoint_conditioner_tb.sv @@
// Self-checking testbench of the six-axis motion setpoint conditioner.
module six_axis_motion_setpoint_conditioner_tb;
    import smsc_pkg::*;

    localparam int VMAX         = 2 ** (VALUE_WIDTH_DEF - 1) - 1;
    localparam int VMIN         = -VMAX - 1;
    localparam int STEP_MAX     = 2 ** STEP_W - 1;
    localparam int IDLE_PCT     = 28;
    localparam int HOLD_CYCLES  = 160;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 140;
    localparam int MAX_REPORTS  = 10;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Testbench-side drivers of the channel signals, known from time zero.
    logic              src_valid = 1'b0;
    t_in_item          src_item  = '0;
    logic              snk_ready = 1'b0;
    logic              cfg_valid = 1'b0;
    t_cfg_reg          cfg_index = REG_MAX_TRANSLATION;
    logic [STEP_W-1:0] cfg_data  = '0;

    smsc_in_if  in_ch ();
    smsc_out_if out_ch ();
    smsc_cfg_if cfg_ch ();

    assign in_ch.valid  = src_valid;
    assign in_ch.data   = src_item;
    assign out_ch.ready = snk_ready;
    assign cfg_ch.valid = cfg_valid;
    assign cfg_ch.index = cfg_index;
    assign cfg_ch.data  = cfg_data;

    six_axis_motion_setpoint_conditioner i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Items waiting to be offered and setpoints the block still owes.
    t_in_item  items_to_send[$];
    t_out_item setpoints_due[$];
    int        mismatches = 0;

    // Pacing controls, set by the stimulus and read by the clocked processes.
    bit src_quiet    = 1'b0;
    bit snk_quiet    = 1'b0;
    bit hold_request = 1'b0;
    bit hold_done    = 1'b0;
    int hold_left    = 0;
    int idle_cycles  = 0;

    // Predictor state: setpoint, the two stored samples and their ids.
    int          cur_sp[AXES];
    int          smp_new[AXES];
    int          smp_old[AXES];
    logic [31:0] id_new     = '0;
    logic [31:0] id_old     = '0;
    bit          sp_pending = 1'b0;
    bit          wait_first = 1'b1;
    int          step_trans = int'(STEP_RESET);
    int          step_rot   = int'(STEP_RESET);

    // Generator state: mirrored sample ids and a random walk per axis.
    logic [31:0] gen_new = '0;
    logic [31:0] gen_old = '0;
    int          walk[AXES];

    initial begin
        foreach (cur_sp[k]) begin
            cur_sp[k]  = 0;
            smp_new[k] = 0;
            smp_old[k] = 0;
            walk[k]    = 0;
        end
    end

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int sat_value(int v);
        if (v > VMAX) return VMAX;
        if (v < VMIN) return VMIN;
        return v;
    endfunction

    // Computes the setpoint the block sends for one item, if any.
    function automatic bit predict_setpoint(input t_in_item it, output t_out_item res);
        int  v[AXES];
        int  lim[AXES];
        int  d;
        int  step;
        bit  extrap;
        v[0] = int'($signed(it.surge_in));
        v[1] = int'($signed(it.sway_in));
        v[2] = int'($signed(it.heave_in));
        v[3] = int'($signed(it.roll_in));
        v[4] = int'($signed(it.pitch_in));
        v[5] = int'($signed(it.yaw_in));
        extrap = 1'b0;
        if (it.cmd == CMD_TICK) begin
            if (sp_pending) begin
                sp_pending = 1'b0;
            end else begin
                // Nothing new: extend the line through the two samples.
                for (int k = 0; k < AXES; k++)
                    cur_sp[k] = sat_value(2 * smp_new[k] - smp_old[k]);
                extrap = 1'b1;
            end
        end else begin
            sp_pending = 1'b1;
            if (it.sequence_id >= id_old) begin
                // Move each axis toward the packet by at most its step.
                for (int k = 0; k < AXES; k++) begin
                    step = (k < TRANS_AXES) ? step_trans : step_rot;
                    d = v[k] - cur_sp[k];
                    if (d > step)
                        lim[k] = sat_value(cur_sp[k] + step);
                    else if (-d > step)
                        lim[k] = sat_value(cur_sp[k] - step);
                    else
                        lim[k] = v[k];
                end
                if (it.sequence_id < id_new) begin
                    smp_old = lim;
                    id_old  = it.sequence_id;
                end else begin
                    smp_old = smp_new;
                    id_old  = id_new;
                    smp_new = lim;
                    id_new  = it.sequence_id;
                    cur_sp  = lim;
                end
            end
            if (!wait_first)
                return 1'b0;
            wait_first = 1'b0;
            sp_pending = 1'b0;
        end
        res.surge_out    = cur_sp[0][FIELD_W-1:0];
        res.sway_out     = cur_sp[1][FIELD_W-1:0];
        res.heave_out    = cur_sp[2][FIELD_W-1:0];
        res.roll_out     = cur_sp[3][FIELD_W-1:0];
        res.pitch_out    = cur_sp[4][FIELD_W-1:0];
        res.yaw_out      = cur_sp[5][FIELD_W-1:0];
        res.extrapolated = extrap;
        return 1'b1;
    endfunction

    function automatic string fmt_setpoint(t_out_item s);
        return $sformatf("(%0d %0d %0d %0d %0d %0d extrap=%0b)",
                         $signed(s.surge_out), $signed(s.sway_out), $signed(s.heave_out),
                         $signed(s.roll_out), $signed(s.pitch_out), $signed(s.yaw_out),
                         s.extrapolated);
    endfunction

    // Ticks carry random don't-care payload.
    task automatic queue_tick();
        t_in_item it;
        it.cmd         = CMD_TICK;
        it.sequence_id = $urandom;
        it.surge_in    = 16'($urandom);
        it.sway_in     = 16'($urandom);
        it.heave_in    = 16'($urandom);
        it.roll_in     = 16'($urandom);
        it.pitch_in    = 16'($urandom);
        it.yaw_in      = 16'($urandom);
        items_to_send.push_back(it);
    endtask

    // Queues a packet and keeps the generator's view of the sample ids.
    task automatic queue_packet(logic [31:0] id, int a, int b, int c, int d, int e, int f);
        t_in_item it;
        it.cmd         = CMD_PACKET;
        it.sequence_id = id;
        it.surge_in    = a[FIELD_W-1:0];
        it.sway_in     = b[FIELD_W-1:0];
        it.heave_in    = c[FIELD_W-1:0];
        it.roll_in     = d[FIELD_W-1:0];
        it.pitch_in    = e[FIELD_W-1:0];
        it.yaw_in      = f[FIELD_W-1:0];
        items_to_send.push_back(it);
        if (id >= gen_old) begin
            if (id < gen_new) begin
                gen_old = id;
            end else begin
                gen_old = gen_new;
                gen_new = id;
            end
        end
    endtask

    // Writes one step register; only called while the block is idle.
    task automatic write_step(t_cfg_reg idx, int val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[STEP_W-1:0];
        do @(posedge i_clk); while (!(cfg_valid && cfg_ch.ready));
        cfg_valid <= 1'b0;
        case (idx)
            REG_MAX_TRANSLATION: step_trans = val & STEP_MAX;
            REG_MAX_ROTATION:    step_rot   = val & STEP_MAX;
        endcase
    endtask

    // Waits until every item is taken and every setpoint has come back.
    task automatic settle_phase();
        while (items_to_send.size() != 0 || src_valid || setpoints_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly in-order packets on a random walk, with stale ones and ticks mixed in.
    task automatic run_random(int count);
        int          r;
        logic [31:0] id;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 35) begin
                queue_tick();
            end else begin
                for (int k = 0; k < AXES; k++) begin
                    r = $urandom_range(99);
                    if (r < 65)
                        walk[k] = sat_value(walk[k] + int'($urandom_range(1200, 0)) - 600);
                    else if (r < 82)
                        walk[k] = int'($signed(16'($urandom)));
                    else if (r < 90)
                        walk[k] = (r % 2 == 0) ? VMAX : VMIN;
                end
                r = $urandom_range(99);
                if (r < 12 && gen_old != 0)
                    id = $urandom_range(gen_old - 1, 0);
                else if (r < 26 && gen_new > gen_old)
                    id = $urandom_range(gen_new - 1, gen_old);
                else if (gen_new > 32'hFFFF_0000)
                    id = gen_new;
                else if (r > 97)
                    id = gen_new + $urandom_range(1 << 22, 1);
                else
                    id = gen_new + $urandom_range(4, 0);
                queue_packet(id, walk[0], walk[1], walk[2], walk[3], walk[4], walk[5]);
            end
        end
    endtask

    // Input driver: predicts on each transfer, then offers the next item.
    always @(posedge i_clk) begin : drive_items
        t_out_item res;
        if (!i_rst_n) begin
            src_valid <= 1'b0;
        end else begin
            if (src_valid && in_ch.ready) begin
                if (predict_setpoint(src_item, res))
                    setpoints_due.push_back(res);
            end
            if (!src_valid || in_ch.ready) begin
                if (items_to_send.size() != 0 && (src_quiet || $urandom_range(99) >= IDLE_PCT)) begin
                    src_item  <= items_to_send.pop_front();
                    src_valid <= 1'b1;
                end else begin
                    src_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver readiness, with one long hold-off counted here.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            snk_ready <= 1'b0;
        end else if (hold_left > 0) begin
            snk_ready <= 1'b0;
            hold_left <= hold_left - 1;
            if (hold_left == 1)
                hold_done <= 1'b1;
        end else if (hold_request && !hold_done) begin
            snk_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end else begin
            snk_ready <= snk_quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Result monitor: each transfer is checked against the oldest setpoint owed.
    always @(posedge i_clk) begin : check_setpoints
        t_out_item want;
        t_out_item got;
        if (i_rst_n && out_ch.valid && snk_ready) begin
            got = out_ch.data;
            if (setpoints_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected setpoint %s", fmt_setpoint(got));
            end else begin
                want = setpoints_due.pop_front();
                if (got.surge_out !== want.surge_out || got.sway_out !== want.sway_out ||
                    got.heave_out !== want.heave_out || got.roll_out !== want.roll_out ||
                    got.pitch_out !== want.pitch_out || got.yaw_out !== want.yaw_out ||
                    got.extrapolated !== want.extrapolated) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("setpoint mismatch: expected %s actual %s",
                                 fmt_setpoint(want), fmt_setpoint(got));
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (src_valid && in_ch.ready) || (out_ch.valid && snk_ready) ||
            (cfg_valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset steps: extrapolation before any packet, the first packet, and
        // newer, in-between, stale and equal ids, with ticks between most of them.
        queue_tick();
        queue_packet(32'd10, VMAX, VMIN, 100, -100, VMAX, -1);
        queue_tick();
        queue_packet(32'd20, 300, -300, 50, 0, 1000, -1000);
        queue_tick();
        queue_packet(32'd15, -5, 5, 500, -500, 0, 0);
        queue_tick();
        queue_packet(32'd5, 1, 2, 3, 4, 5, 6);
        queue_tick();
        queue_packet(32'd15, 7, 7, 7, 7, 7, 7);
        queue_packet(32'd20, -7, -7, -7, -7, -7, -7);
        queue_tick();
        queue_tick();
        settle_phase();

        // Widest steps: full-scale swings, and extrapolation that saturates at the low end.
        write_step(REG_MAX_TRANSLATION, STEP_MAX);
        write_step(REG_MAX_ROTATION, STEP_MAX);
        queue_packet(32'd30, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX);
        queue_packet(32'd31, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN);
        queue_tick();
        queue_tick();
        queue_packet(32'd32, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX);
        queue_tick();
        queue_tick();
        settle_phase();

        // Zero step: the setpoint cannot move.
        write_step(REG_MAX_TRANSLATION, 0);
        write_step(REG_MAX_ROTATION, 0);
        queue_packet(32'd40, VMIN, VMAX, 1, -1, VMAX, VMIN);
        queue_tick();
        settle_phase();

        // Moderate steps.
        write_step(REG_MAX_TRANSLATION, $urandom_range(700, 100));
        write_step(REG_MAX_ROTATION, $urandom_range(700, 100));
        run_random(PHASE_ITEMS);
        settle_phase();

        // Receiver holds off while the sender keeps pushing.
        write_step(REG_MAX_TRANSLATION, STEP_MAX);
        write_step(REG_MAX_ROTATION, 0);
        src_quiet    = 1'b1;
        hold_request = 1'b1;
        run_random(PHASE_ITEMS);
        settle_phase();
        src_quiet = 1'b0;

        // Both sides at full rate.
        write_step(REG_MAX_TRANSLATION, 0);
        write_step(REG_MAX_ROTATION, STEP_MAX);
        src_quiet = 1'b1;
        snk_quiet = 1'b1;
        run_random(PHASE_ITEMS);
        settle_phase();
        src_quiet = 1'b0;
        snk_quiet = 1'b0;

        write_step(REG_MAX_TRANSLATION, $urandom_range(STEP_MAX, 0));
        write_step(REG_MAX_ROTATION, $urandom_range(STEP_MAX, 0));
        run_random(PHASE_ITEMS);
        settle_phase();

        write_step(REG_MAX_TRANSLATION, 1);
        write_step(REG_MAX_ROTATION, STEP_MAX - 1);
        run_random(PHASE_ITEMS);
        settle_phase();

        // Back to reset steps, with ids moved into the upper range and the
        // largest id last, followed by a stale zero id.
        write_step(REG_MAX_TRANSLATION, int'(STEP_RESET));
        write_step(REG_MAX_ROTATION, int'(STEP_RESET));
        queue_packet($urandom_range(32'hE000_0000, 32'hC000_0000),
                     walk[0], walk[1], walk[2], walk[3], walk[4], walk[5]);
        run_random(PHASE_ITEMS);
        queue_packet(32'hFFFF_FFFF, VMAX, VMIN, 0, VMAX, VMIN, 0);
        queue_packet(32'd0, 1, 1, 1, 1, 1, 1);
        queue_tick();
        settle_phase();

        if (mismatches == 0 && setpoints_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/smsc_pkg.sv
hw/rtl/smsc_ifs.sv
hw/rtl/smsc_ctrl.sv
hw/rtl/smsc_axis.sv
hw/rtl/six_axis_motion_setpoint_conditioner.sv
test/six_axis_motion_setpoint_conditioner_tb.sv
